// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module.
// Every macro samples on the rising edge of clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i.
`define QCRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define QCRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  `QCRR_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/qcrr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcrr_pkg
// Shared types and constants of the QUIC connection-id route rewriter.
// ----------------------------------------------------------------------------
package qcrr_pkg;

  // Default sizes.
  localparam int TableDepthDef = 64;
  localparam int HdrWordsDef   = 24;

  // Header field values.
  localparam logic [15:0] EthTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam logic [7:0]  QuicMask    = 8'hC0;
  localparam logic [7:0]  QuicShort   = 8'h40;
  localparam logic [3:0]  IhlMin      = 4'd5;

  // Input command codes.
  localparam logic CmdData  = 1'b0;
  localparam logic CmdTable = 1'b1;

  // One table slot.
  typedef struct packed {
    logic [63:0] key;
    logic [31:0] ip;
    logic [15:0] port;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
  } qcrr_entry_t;

  // Outcome of the header check after one word.
  typedef enum logic [1:0] {
    DEC_WAIT,
    DEC_PASS,
    DEC_SCAN
  } qcrr_dec_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_SCAN,
    ST_FLUSH,
    ST_STREAM
  } qcrr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic tbl_wr;
    logic set_pass;
    logic scan_start;
    logic scan_run;
    logic flush_load;
    logic pass_load;
  } qcrr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    qcrr_dec_e dec;
    logic      scan_hit;
    logic      scan_miss;
    logic      flush_end;
    logic      fin_last;
    logic      out_free;
  } qcrr_status_t;

endpackage
`default_nettype wire

// ===== rtl/quic_cid_route_rewriter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quic_cid_route_rewriter
// Steers QUIC short-header packets by destination connection id and
// rewrites their addresses and ports from a route table.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries packet words (cmd 0) and table writes (cmd 1).
//   A table write makes no output word.
//   Header words are taken one per cycle and held until the verdict is
//   known, at the latest once the eighth connection-id byte has arrived.
//   A packet that needs a table lookup then stalls input for a scan of
//   up to TABLE_DEPTH slots: the table memory is read one slot per
//   cycle through its single read port, and the lowest matching slot wins.
//   The held words (n of them) are then flushed, rewritten when the
//   verdict is transmit, one per cycle while the output register is free;
//   later words of the packet stream through it at one word per cycle.
//   A stall on the output channel holds the output word and, once that
//   register is full, stalls the input channel.
//   Reset clears all slot valid bits and the packet state; the table
//   memory itself is not cleared.
// ----------------------------------------------------------------------------
module quic_cid_route_rewriter #(
  parameter int TABLE_DEPTH = qcrr_pkg::TableDepthDef,
  parameter int HDR_WORDS   = qcrr_pkg::HdrWordsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_i,
  input  wire logic [31:0] data_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_word_i,
  input  wire logic [5:0]  slot_i,
  input  wire logic        entry_valid_i,
  input  wire logic [63:0] entry_key_i,
  input  wire logic [31:0] route_ip_i,
  input  wire logic [15:0] route_port_i,
  input  wire logic [47:0] route_dst_mac_i,
  input  wire logic [47:0] route_src_mac_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      out_word_o,
  output logic [2:0]       out_byte_count_o,
  output logic             out_last_o,
  output logic             verdict_o
);
  import qcrr_pkg::*;

  qcrr_cmd_t    ctrl;
  qcrr_status_t status;

  // Sequencer.
  qcrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .last_word_i (last_word_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  // Datapath.
  qcrr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HDR_WORDS   (HDR_WORDS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .data_word_i      (data_word_i),
    .byte_count_i     (byte_count_i),
    .last_word_i      (last_word_i),
    .slot_i           (slot_i),
    .entry_valid_i    (entry_valid_i),
    .entry_key_i      (entry_key_i),
    .route_ip_i       (route_ip_i),
    .route_port_i     (route_port_i),
    .route_dst_mac_i  (route_dst_mac_i),
    .route_src_mac_i  (route_src_mac_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_word_o       (out_word_o),
    .out_byte_count_o (out_byte_count_o),
    .out_last_o       (out_last_o),
    .verdict_o        (verdict_o)
  );

endmodule
`default_nettype wire

// ===== rtl/qcrr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcrr_ctrl
// Sequencer: collects the header, runs the table scan if one is needed,
// flushes the held words and then streams the rest of the packet.
// ----------------------------------------------------------------------------
module qcrr_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic                   cmd_i,
  input  wire logic                   last_word_i,
  output logic                        in_stall_o,
  input  wire qcrr_pkg::qcrr_status_t status_i,
  output qcrr_pkg::qcrr_cmd_t         ctrl_o
);
  import qcrr_pkg::*;

  qcrr_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_COLLECT: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (cmd_i == CmdTable) begin
            ctrl_o.tbl_wr = 1'b1;
          end else begin
            ctrl_o.capture = 1'b1;
            case (status_i.dec)
              DEC_PASS: begin
                ctrl_o.set_pass = 1'b1;
                state_d         = ST_FLUSH;
              end
              DEC_SCAN: begin
                ctrl_o.scan_start = 1'b1;
                state_d           = ST_SCAN;
              end
              default: begin
                state_d = ST_COLLECT;
              end
            endcase
          end
        end
      end
      ST_SCAN: begin
        ctrl_o.scan_run = 1'b1;
        if (status_i.scan_hit || status_i.scan_miss) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          ctrl_o.flush_load = 1'b1;
          if (status_i.flush_end) begin
            state_d = status_i.fin_last ? ST_COLLECT : ST_STREAM;
          end
        end
      end
      ST_STREAM: begin
        in_stall_o = !status_i.out_free;
        if (in_valid_i && status_i.out_free) begin
          if (cmd_i == CmdTable) begin
            ctrl_o.tbl_wr = 1'b1;
          end else begin
            ctrl_o.pass_load = 1'b1;
            if (last_word_i) begin
              state_d = ST_COLLECT;
            end
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/qcrr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcrr_dp
// Datapath: header store and parser, route table with its scan, header
// rewrite and the output register.
// ----------------------------------------------------------------------------
module qcrr_dp #(
  parameter int TABLE_DEPTH = qcrr_pkg::TableDepthDef,
  parameter int HDR_WORDS   = qcrr_pkg::HdrWordsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire qcrr_pkg::qcrr_cmd_t    ctrl_i,
  output qcrr_pkg::qcrr_status_t      status_o,
  input  wire logic [31:0]            data_word_i,
  input  wire logic [2:0]             byte_count_i,
  input  wire logic                   last_word_i,
  input  wire logic [5:0]             slot_i,
  input  wire logic                   entry_valid_i,
  input  wire logic [63:0]            entry_key_i,
  input  wire logic [31:0]            route_ip_i,
  input  wire logic [15:0]            route_port_i,
  input  wire logic [47:0]            route_dst_mac_i,
  input  wire logic [47:0]            route_src_mac_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [31:0]                 out_word_o,
  output logic [2:0]                  out_byte_count_o,
  output logic                        out_last_o,
  output logic                        verdict_o
);
  import qcrr_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = $clog2(HDR_WORDS);
  localparam int IW = $clog2(HDR_WORDS + 1);
  localparam int OW = IW + 3;

  // Fixed byte and word positions of the frame.
  localparam logic [OW-1:0] EthLen     = OW'(14);
  localparam logic [OW-1:0] IpMinEnd   = OW'(34);
  localparam logic [OW-1:0] QuicOffs   = OW'(23);
  localparam logic [OW-1:0] DcidOffs   = OW'(31);
  localparam logic [OW-1:0] ChkByte    = OW'(24);
  localparam logic [OW-1:0] DipByteHi  = OW'(30);
  localparam logic [OW-1:0] DipByteLo  = OW'(32);
  localparam logic [OW-1:0] WordEth    = OW'(3);
  localparam logic [OW-1:0] WordProto  = OW'(5);
  localparam logic [OW-1:0] WordChk    = OW'(6);
  localparam logic [OW-1:0] WordDipHi  = OW'(7);
  localparam logic [OW-1:0] WordDipLo  = OW'(8);
  localparam logic [OW-1:0] QuicWordLo = OW'(5);

  // ---------------- Header collection and parsing ----------------
  logic [31:0]     store_q [HDR_WORDS];
  logic [IW-1:0]   idx_q;
  logic [SW-1:0]   widx;
  logic [OW-1:0]   wi;
  logic [2:0]      cnt_n;
  logic [OW-1:0]   avail;
  logic [15:0]     eth_q, eth_d;
  logic [3:0]      ihl_q, ihl_d;
  logic [7:0]      proto_q, proto_d;
  logic [7:0]      qb_q, qb_d;
  logic [63:0]     key_q, key_d;
  logic [21:0]     acc_q, acc_d;
  logic [OW-1:0]   mw, hend, b0, b1;
  logic [SW-1:0]   lidx_q;
  logic [2:0]      fin_cnt_q;
  logic            fin_last_q;
  qcrr_dec_e       dec;

  // The write index stops at the last word of the store.
  always_comb begin
    if (idx_q >= IW'(HDR_WORDS - 1)) begin
      widx = SW'(HDR_WORDS - 1);
    end else begin
      widx = idx_q[SW-1:0];
    end
  end

  assign wi    = OW'(widx);
  assign cnt_n = (!last_word_i || byte_count_i == 3'd0 || byte_count_i > 3'd4) ?
                 3'd4 : byte_count_i;
  assign avail = OW'({widx, 2'b00}) + OW'(cnt_n);

  // Field capture with the current word merged in.
  always_comb begin
    eth_d   = (wi == WordEth) ? data_word_i[31:16] : eth_q;
    ihl_d   = (wi == WordEth) ? data_word_i[11:8] : ihl_q;
    proto_d = (wi == WordProto) ? data_word_i[7:0] : proto_q;
    mw      = OW'(ihl_d) + QuicWordLo;
    qb_d    = (wi == mw) ? data_word_i[15:8] : qb_q;
    key_d   = key_q;
    if (wi == mw) begin
      key_d[63:56] = data_word_i[7:0];
    end
    if (wi == mw + OW'(1)) begin
      key_d[55:24] = data_word_i;
    end
    if (wi == mw + OW'(2)) begin
      key_d[23:0] = data_word_i[31:8];
    end
  end

  // Running sum of the IP header halfwords, leaving out the checksum and
  // the destination address.
  always_comb begin
    hend  = OW'({ihl_d, 2'b00}) + EthLen;
    b0    = OW'({widx, 2'b00});
    b1    = b0 + OW'(2);
    acc_d = (widx == '0) ? '0 : acc_q;
    if (b0 >= EthLen && b0 < hend && b0 != ChkByte && b0 != DipByteHi &&
        b0 != DipByteLo) begin
      acc_d = acc_d + 22'(data_word_i[31:16]);
    end
    if (b1 >= EthLen && b1 < hend && b1 != ChkByte && b1 != DipByteHi &&
        b1 != DipByteLo) begin
      acc_d = acc_d + 22'(data_word_i[15:0]);
    end
  end

  // Header check in the order of its fields.
  always_comb begin
    if (avail < EthLen) begin
      dec = DEC_WAIT;
    end else if (eth_d != EthTypeIpv4) begin
      dec = DEC_PASS;
    end else if (avail < IpMinEnd) begin
      dec = DEC_WAIT;
    end else if (proto_d != ProtoUdp || ihl_d < IhlMin) begin
      dec = DEC_PASS;
    end else if (avail < OW'({ihl_d, 2'b00}) + QuicOffs) begin
      dec = DEC_WAIT;
    end else if ((qb_d & QuicMask) != QuicShort) begin
      dec = DEC_PASS;
    end else if (avail < OW'({ihl_d, 2'b00}) + DcidOffs) begin
      dec = DEC_WAIT;
    end else begin
      dec = DEC_SCAN;
    end
    if (dec == DEC_WAIT && last_word_i) begin
      dec = DEC_PASS;
    end
  end

  // Header store.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      store_q[widx] <= data_word_i;
      eth_q         <= eth_d;
      ihl_q         <= ihl_d;
      proto_q       <= proto_d;
      qb_q          <= qb_d;
      key_q         <= key_d;
      acc_q         <= acc_d;
      lidx_q        <= widx;
      fin_cnt_q     <= cnt_n;
      fin_last_q    <= last_word_i;
    end
  end

  // Word index of the packet being collected.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (ctrl_i.capture) begin
      idx_q <= (dec == DEC_WAIT) ? IW'(widx) + IW'(1) : '0;
    end
  end

  // ---------------- Route table ----------------
  qcrr_entry_t            mem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] slot_valid_q;
  logic [AW-1:0]          waddr;
  logic                   wr_ok;
  qcrr_entry_t            rd_q;
  logic                   rdv_q, live_q, issue_q;
  logic [AW-1:0]          saddr_q;
  logic                   match;

  assign waddr = AW'(slot_i);
  assign wr_ok = ctrl_i.tbl_wr && (32'(slot_i) < 32'(TABLE_DEPTH));

  // Table memory: one write port, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[waddr] <= '{key: entry_key_i, ip: route_ip_i, port: route_port_i,
                        dst_mac: route_dst_mac_i, src_mac: route_src_mac_i};
    end
    if (ctrl_i.scan_run && issue_q) begin
      rd_q <= mem_q[saddr_q];
    end
  end

  // Slot valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (wr_ok) begin
      slot_valid_q[waddr] <= entry_valid_i;
    end
  end

  // Scan from slot zero upward; the first match ends it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saddr_q <= '0;
      issue_q <= 1'b0;
      live_q  <= 1'b0;
      rdv_q   <= 1'b0;
    end else if (ctrl_i.scan_start) begin
      saddr_q <= '0;
      issue_q <= 1'b1;
      live_q  <= 1'b0;
    end else if (ctrl_i.scan_run) begin
      live_q <= issue_q;
      if (issue_q) begin
        rdv_q   <= slot_valid_q[saddr_q];
        saddr_q <= saddr_q + AW'(1);
        if (saddr_q == AW'(TABLE_DEPTH - 1)) begin
          issue_q <= 1'b0;
        end
      end
    end
  end

  assign match = live_q && rdv_q && (rd_q.key == key_q);

  // ---------------- Verdict and route of the packet ----------------
  logic        hit_q;
  qcrr_entry_t route_q;
  logic [21:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.set_pass) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.scan_run && (match || status_o.scan_miss)) begin
      hit_q <= match;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_run && match) begin
      route_q <= rd_q;
      sum_q   <= acc_q + 22'(rd_q.ip[31:16]) + 22'(rd_q.ip[15:0]);
    end
  end

  // ---------------- Flush with rewrite ----------------
  logic [SW-1:0] fidx_q;
  logic [OW-1:0] fw, mq;
  logic [31:0]   patched;
  logic [16:0]   fold1, fold2;
  logic [15:0]   csum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fidx_q <= '0;
    end else if (ctrl_i.flush_load) begin
      fidx_q <= (fidx_q == lidx_q) ? '0 : fidx_q + SW'(1);
    end
  end

  // Folded and inverted IP header checksum.
  assign fold1 = 17'(sum_q[15:0]) + 17'(sum_q[21:16]);
  assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
  assign csum  = ~fold2[15:0];

  assign fw = OW'(fidx_q);
  assign mq = OW'(ihl_q) + QuicWordLo;

  // Replace the routed fields in the held word.
  always_comb begin
    patched = store_q[fidx_q];
    if (hit_q) begin
      if (fw == OW'(0)) begin
        patched = route_q.dst_mac[47:16];
      end else if (fw == OW'(1)) begin
        patched = {route_q.dst_mac[15:0], route_q.src_mac[47:32]};
      end else if (fw == OW'(2)) begin
        patched = route_q.src_mac[31:0];
      end else if (fw == WordChk) begin
        patched[31:16] = csum;
      end else if (fw == WordDipHi) begin
        patched[15:0] = route_q.ip[31:16];
      end else if (fw == WordDipLo) begin
        patched[31:16] = route_q.ip[15:0];
      end else if (fw == mq - OW'(1)) begin
        patched[31:16] = route_q.port;
      end else if (fw == mq) begin
        patched[31:16] = '0;
      end
    end
  end

  // ---------------- Output register ----------------
  logic out_free;

  assign out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ctrl_i.flush_load || ctrl_i.pass_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.flush_load) begin
      out_word_o       <= patched;
      out_byte_count_o <= (fidx_q == lidx_q) ? fin_cnt_q : 3'd4;
      out_last_o       <= (fidx_q == lidx_q) && fin_last_q;
      verdict_o        <= hit_q;
    end else if (ctrl_i.pass_load) begin
      out_word_o       <= data_word_i;
      out_byte_count_o <= cnt_n;
      out_last_o       <= last_word_i;
      verdict_o        <= hit_q;
    end
  end

  // Status to the controller.
  always_comb begin
    status_o.dec       = dec;
    status_o.scan_hit  = match;
    status_o.scan_miss = live_q && !match && !issue_q;
    status_o.flush_end = (fidx_q == lidx_q);
    status_o.fin_last  = fin_last_q;
    status_o.out_free  = out_free;
  end

endmodule
`default_nettype wire

// ===== rtl/qcrr_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qcrr_chk
// Port-level checks on the output channel of the route rewriter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qcrr_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] out_word_o,
  input wire logic [2:0]  out_byte_count_o,
  input wire logic        out_last_o,
  input wire logic        verdict_o
);

  logic in_pkt_q;
  logic verd_q;

  // Tracks the verdict of the packet being delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q <= 1'b0;
      verd_q   <= 1'b0;
    end else if (out_valid_o && !out_stall_i) begin
      in_pkt_q <= !out_last_o;
      verd_q   <= verdict_o;
    end
  end

  `QCRR_ASSERT(a_cnt_range, out_valid_o |-> (out_byte_count_o != 3'd0 && out_byte_count_o <= 3'd4), "bad count")
  `QCRR_ASSERT(a_full_mid, (out_valid_o && !out_last_o) |-> (out_byte_count_o == 3'd4), "short word before the end")
  `QCRR_ASSERT(a_verdict_same, (out_valid_o && in_pkt_q) |-> (verdict_o == verd_q), "verdict changed inside a packet")
  `QCRR_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled word changed")

endmodule

bind quic_cid_route_rewriter qcrr_chk u_chk (.*);
`default_nettype wire
